>>> sv/aup_pkg.sv
// Shared types and constants for the ASCII unsigned integer parser.
// No dependencies; imported by aup_front, aup_back and the top level.
package aup_pkg;

   localparam int DEFAULT_MAX_LEN = 4096;
   localparam int RADIX_W         = 6;
   localparam int VALUE_W         = 64;
   localparam int OFFSET_W        = 13;
   localparam int DIGIT_W         = 6;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int QUEUE_DEPTH     = 2;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] RADIX_ADDR = 3'd0;

   localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_BAD   = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   // one character after classification
   typedef struct packed {
      logic               term;     // NUL, ends the string
      logic               space;
      logic               plus;
      logic               minus;
      logic               zero;     // '0'
      logic               hex_x;    // 'x' or 'X'
      logic [DIGIT_W-1:0] digit;    // 0..35, NOT_A_DIGIT otherwise
   } char_class_type;

   localparam int CLASS_W = $bits(char_class_type);

   // one result item
   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic                overflowed;
      logic [OFFSET_W-1:0] end_offset;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

>>> sv/aup_fifo.sv
// Small register-based queue, generic in width and depth.
// No dependencies; used between front and back and as the result queue.
module aup_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/aup_front.sv
// Front end: accepts characters and classifies them for the parser.
// Depends on aup_pkg and aup_fifo (the queue toward the back end).
module aup_front
   import aup_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  logic [7:0]     char_code,
   output logic           full,
   input  logic           item_pop,
   output char_class_type item,
   output logic           item_valid
);

   char_class_type cls;
   logic [CLASS_W-1:0] q_rd;
   logic q_empty;

   always_comb begin
      cls       = '0;
      cls.term  = (char_code == 8'd0);
      cls.space = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
      cls.plus  = (char_code == 8'd43);
      cls.minus = (char_code == 8'd45);
      cls.zero  = (char_code == 8'd48);
      cls.hex_x = (char_code == 8'd120) || (char_code == 8'd88);
      if (char_code >= 8'd48 && char_code <= 8'd57) begin
         cls.digit = DIGIT_W'(char_code - 8'd48);
      end else if (char_code >= 8'd65 && char_code <= 8'd90) begin
         cls.digit = DIGIT_W'(char_code - 8'd55);
      end else if (char_code >= 8'd97 && char_code <= 8'd122) begin
         cls.digit = DIGIT_W'(char_code - 8'd87);
      end else begin
         cls.digit = NOT_A_DIGIT;
      end
   end

   aup_fifo #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_class_q (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (cls),
      .full    (full),
      .pop     (item_pop),
      .rd_data (q_rd),
      .empty   (q_empty)
   );

   assign item       = char_class_type'(q_rd);
   assign item_valid = !q_empty;

endmodule

>>> sv/aup_back.sv
// Back end: string parser state machine with the 64-bit accumulator.
// Depends on aup_pkg; fed by aup_front, feeds the result queue.
module aup_back
   import aup_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [RADIX_W-1:0] radix,
   input  char_class_type     item,
   input  logic               item_valid,
   output logic               item_pop,
   input  logic               out_full,
   output logic               out_push,
   output result_type         out_result
);

   localparam int POS_W = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      PH_SPACE, PH_SIGNED, PH_ZERO, PH_HEXX, PH_DIGITS, PH_STOPPED
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic [RADIX_W-1:0]   base_ff, base_in;
   logic                 neg_ff, neg_in;
   logic                 ovf_ff, ovf_in;
   logic                 conv_ff, conv_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     stop_ff, stop_in;

   logic                 proceed, first, take;
   logic [RADIX_W-1:0]   tb;
   logic [POS_W-1:0]     pos_inc;
   logic [VALUE_W+RADIX_W-1:0] prod;
   logic [POS_W+OFFSET_W-1:0]  stop_ext;

   assign proceed  = item_valid && !out_full;
   assign item_pop = proceed;
   assign out_push = proceed && item.term;
   assign pos_inc  = (pos_ff < POS_W'(MAX_LEN)) ? pos_ff + 1'b1 : pos_ff;
   assign prod     = (VALUE_W+RADIX_W)'(acc_ff) * (VALUE_W+RADIX_W)'(tb)
                   + (VALUE_W+RADIX_W)'(item.digit);
   assign stop_ext = {{OFFSET_W{1'b0}}, stop_ff};

   always_comb begin
      out_result.value      = ovf_ff ? {VALUE_W{1'b1}} : (neg_ff ? -acc_ff : acc_ff);
      out_result.overflowed = ovf_ff;
      out_result.end_offset = conv_ff ? stop_ext[OFFSET_W-1:0] : '0;
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      conv_in  = conv_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      first    = 1'b0;
      take     = 1'b0;
      tb       = base_ff;
      if (proceed) begin
         if (item.term) begin
            phase_in = PH_SPACE;
            acc_in   = '0;
            base_in  = '0;
            neg_in   = 1'b0;
            ovf_in   = 1'b0;
            conv_in  = 1'b0;
            pos_in   = '0;
            stop_in  = '0;
         end else begin
            case (phase_ff)
               PH_SPACE: begin
                  if (item.space) begin
                     pos_in = pos_inc;
                  end else if (item.plus || item.minus) begin
                     neg_in   = item.minus;
                     pos_in   = pos_inc;
                     phase_in = PH_SIGNED;
                  end else begin
                     first = 1'b1;
                  end
               end
               PH_SIGNED: begin
                  first = 1'b1;
               end
               PH_ZERO: begin
                  if (item.hex_x) begin
                     base_in  = RADIX_HEX;
                     pos_in   = pos_inc;
                     phase_in = PH_HEXX;
                  end else begin
                     take = 1'b1;
                     tb   = (base_ff == RADIX_AUTO) ? RADIX_OCT : base_ff;
                  end
               end
               PH_HEXX: begin
                  take = 1'b1;
                  tb   = RADIX_HEX;
               end
               PH_DIGITS: begin
                  take = 1'b1;
                  tb   = base_ff;
               end
               default: begin
                  phase_in = PH_STOPPED;
               end
            endcase

            // first character after whitespace and sign samples the radix
            if (first) begin
               if (radix == RADIX_BAD || radix > RADIX_MAX) begin
                  phase_in = PH_STOPPED;
               end else if ((radix == RADIX_AUTO || radix == RADIX_HEX) && item.zero) begin
                  base_in  = radix;
                  conv_in  = 1'b1;
                  pos_in   = pos_inc;
                  stop_in  = pos_inc;
                  phase_in = PH_ZERO;
               end else begin
                  take = 1'b1;
                  tb   = (radix == RADIX_AUTO) ? RADIX_DEC : radix;
               end
            end

            if (take) begin
               base_in = tb;
               if (tb < 6'd2 || item.digit >= tb) begin
                  phase_in = PH_STOPPED;
               end else begin
                  if (ovf_ff || prod[VALUE_W+RADIX_W-1:VALUE_W] != '0) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = prod[VALUE_W-1:0];
                  end
                  conv_in  = 1'b1;
                  pos_in   = pos_inc;
                  stop_in  = pos_inc;
                  phase_in = PH_DIGITS;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         acc_ff   <= '0;
         base_ff  <= '0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         conv_ff  <= 1'b0;
         pos_ff   <= '0;
         stop_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         conv_ff  <= conv_in;
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

>>> sv/ascii_unsigned_integer_parser.sv
// ASCII unsigned integer parser, top level (strtoul semantics).
// Depends on aup_pkg, aup_fifo, aup_front and aup_back.
//
// Usage:
//  - Input queue: one character per item on req_char_code, taken when
//    req_push is high and req_full is low. A NUL ends the string; only the
//    NUL produces a result item, every other character produces nothing.
//  - Result queue: value, overflowed and end_offset of the oldest result
//    sit on the rsp_ ports while rsp_empty is low; rsp_pop takes it.
//  - CSR port (APB style): radix at byte address 0. Base 0 = auto detect
//    (0x hex, leading 0 octal, else decimal); 1 and above 36 are invalid.
//    The radix is sampled at the first character after whitespace and sign.
//    Write it only when the block is idle.
//  - Throughput: one character per cycle while the result queue has room.
//    One 64x6 multiply-add per cycle, overflow checked on the carry-outs.
//  - Path: a NUL goes through the character queue, then the parser into the
//    result queue, whose oldest entry sits on the rsp_ ports.
//  - Stall: the two-entry result queue fills while rsp_pop is low; the
//    parser then holds, the character queue fills and req_full rises.
//  - Reset: queues empty, parser at leading whitespace, radix 0 (auto).
module ascii_unsigned_integer_parser
   import aup_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   // character input
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_char_code,
   // results
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [VALUE_W-1:0]    rsp_value,
   output logic                  rsp_overflowed,
   output logic [OFFSET_W-1:0]   rsp_end_offset,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               csr_write;

   char_class_type     item;
   logic               item_valid, item_pop;
   logic               res_full, res_push;
   result_type         res_wr;
   logic [RESULT_W-1:0] res_rd;
   result_type         res_head;

   // config register: written in the APB access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign radix_in   = (csr_write && csr_paddr == RADIX_ADDR) ?
                       csr_pwdata[RADIX_W-1:0] : radix_ff;
   assign csr_prdata = (csr_paddr == RADIX_ADDR) ?
                       {{(CSR_DATA_W-RADIX_W){1'b0}}, radix_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_AUTO;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // front end: classify and queue characters
   aup_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .char_code  (req_char_code),
      .full       (req_full),
      .item_pop   (item_pop),
      .item       (item),
      .item_valid (item_valid)
   );

   // back end: parser state machine
   aup_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .radix      (radix_ff),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .out_full   (res_full),
      .out_push   (res_push),
      .out_result (res_wr)
   );

   // result queue decouples the parser from the consumer
   aup_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_rd),
      .empty   (rsp_empty)
   );

   assign res_head       = result_type'(res_rd);
   assign rsp_value      = res_head.value;
   assign rsp_overflowed = res_head.overflowed;
   assign rsp_end_offset = res_head.end_offset;

endmodule
